// File: sv/dtaf_pkg.sv
// ----------------------------------------------------------------------------
// dtaf_pkg: shared types and constants of the duration formatter
// Job and field records, character codes, string lengths, digit helpers.
// ----------------------------------------------------------------------------
package dtaf_pkg;

   localparam int SECS_WIDTH = 50;
   localparam int SUB_WIDTH  = 32;

   // fraction mode codes
   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_MICRO = 2'd1;
   localparam logic [1:0] MODE_NANO  = 2'd2;
   // unused code, formats as MODE_NONE
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // character codes (low six bits of ASCII)
   localparam logic [5:0] CHAR_ZERO  = 6'h30;
   localparam logic [5:0] CHAR_COLON = 6'h3a;
   localparam logic [5:0] CHAR_DOT   = 6'h2e;
   localparam logic [5:0] CHAR_SPACE = 6'h20;

   // string lengths per mode
   localparam logic [4:0] LEN_NONE  = 5'd19;
   localparam logic [4:0] LEN_MICRO = 5'd26;
   localparam logic [4:0] LEN_NANO  = 5'd29;

   // conversion steps: two input bits per step
   localparam logic [4:0] CONV_STEPS = 5'd25;
   localparam logic [4:0] FRAC_STEPS = 5'd16;

   typedef struct packed {
      logic [SECS_WIDTH-1:0] secs;
      logic [SUB_WIDTH-1:0]  mag;
      logic [1:0]            mode;
   } job_type;

   typedef struct packed {
      logic [9:0][3:0] days;
      logic [4:0]      hours;
      logic [5:0]      mins;
      logic [5:0]      secs;
      logic [8:0][3:0] frac;
      logic [1:0]      mode;
   } fields_type;

   // One mixed-radix doubling: shift one bit into seconds and one into the
   // fraction. Each carry depends only on its own digit, so no ripple.
   function automatic fields_type dbl_step(input fields_type f, input logic sb,
                                           input logic fb, input logic fen);
      fields_type r;
      logic       c_sec;
      logic       c_min;
      logic       c_hr;
      logic [9:0] c_day;
      logic [8:0] c_frac;
      logic [6:0] t;
      logic [5:0] h;
      logic [4:0] d;
      integer     i;
      r = f;
      c_sec = (f.secs >= 6'd30);
      t = 7'({f.secs, 1'b0}) + 7'(sb);
      r.secs = c_sec ? 6'(t - 7'd60) : t[5:0];
      c_min = (f.mins >= 6'd30);
      t = 7'({f.mins, 1'b0}) + 7'(c_sec);
      r.mins = c_min ? 6'(t - 7'd60) : t[5:0];
      c_hr = (f.hours >= 5'd12);
      h = 6'({f.hours, 1'b0}) + 6'(c_min);
      r.hours = c_hr ? 5'(h - 6'd24) : h[4:0];
      for (i = 0; i < 10; i++) begin
         c_day[i] = (f.days[i] >= 4'd5);
         d = 5'({f.days[i], 1'b0}) + 5'((i == 0) ? c_hr : c_day[(i == 0) ? 0 : i - 1]);
         r.days[i] = c_day[i] ? 4'(d - 5'd10) : d[3:0];
      end
      if (fen) begin
         for (i = 0; i < 9; i++) begin
            c_frac[i] = (f.frac[i] >= 4'd5);
            d = 5'({f.frac[i], 1'b0}) + 5'((i == 0) ? fb : c_frac[(i == 0) ? 0 : i - 1]);
            r.frac[i] = c_frac[i] ? 4'(d - 5'd10) : d[3:0];
         end
      end
      return r;
   endfunction

   // tens digit of a value below sixty
   function automatic logic [2:0] tens_of(input logic [5:0] v);
      logic [2:0] r;
      if (v >= 6'd50) r = 3'd5;
      else if (v >= 6'd40) r = 3'd4;
      else if (v >= 6'd30) r = 3'd3;
      else if (v >= 6'd20) r = 3'd2;
      else if (v >= 6'd10) r = 3'd1;
      else r = 3'd0;
      return r;
   endfunction

   function automatic logic [5:0] tens_char(input logic [5:0] v);
      return CHAR_ZERO + 6'(tens_of(v));
   endfunction

   function automatic logic [5:0] units_char(input logic [5:0] v);
      logic [5:0] ten;
      ten = 6'(tens_of(v)) * 6'd10;
      return CHAR_ZERO + 6'(v - ten);
   endfunction

endpackage

// File: sv/duration_to_ascii_formatter_unit.sv
// ----------------------------------------------------------------------------
// duration_to_ascii_formatter_unit: duration to text streamer
// Formats seconds and sub-seconds as "dddddddddd hh:mm:ss[.fraction]".
// ----------------------------------------------------------------------------
// Each request yields 19, 26 or 29 characters, one per cycle on the response
// channel while the receiver accepts them, with tlast on the final one. A
// request is converted by a mixed-radix shifter taking two bits a cycle,
// overlapped with the emission of the previous string, and a two-entry queue
// holds waiting requests.
// fraction_mode is sampled when a request is taken; mode 3 acts as mode 0.
module duration_to_ascii_formatter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // whole_seconds[49:0], sub_second[81:50], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // character[5:0], zero pad
   output logic        rsp_tlast    // last_char
);

   logic [1:0]           mode_ff;
   logic                 job_valid, job_take;
   dtaf_pkg::job_type    job;
   logic                 fld_valid, fld_take;
   dtaf_pkg::fields_type fld;
   logic [5:0]           rsp_char;

   // hold fraction mode
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= dtaf_pkg::MODE_NONE;
      else if (csr_we) mode_ff <= csr_wdata;
   end

   dtaf_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .secs(req_tdata[49:0]), .sub(req_tdata[81:50]), .mode(mode_ff),
      .job_valid(job_valid), .job_take(job_take), .job(job)
   );

   dtaf_convert u_convert (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job_take(job_take), .job(job),
      .fld_valid(fld_valid), .fld_take(fld_take), .fld(fld)
   );

   dtaf_emit u_emit (
      .clock(clock), .reset(reset),
      .fld_valid(fld_valid), .fld_take(fld_take), .fld(fld),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_char(rsp_char), .rsp_last(rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_char};

endmodule

// File: sv/dtaf_front.sv
// ----------------------------------------------------------------------------
// dtaf_front: request intake and job queue
// Takes requests, forms the sub-second magnitude, queues up to two jobs.
// ----------------------------------------------------------------------------
module dtaf_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dtaf_pkg::SECS_WIDTH-1:0] secs,
   input  logic [dtaf_pkg::SUB_WIDTH-1:0]  sub,
   input  logic [1:0]                      mode,
   output logic                            job_valid,
   input  logic                            job_take,
   output dtaf_pkg::job_type               job
);

   dtaf_pkg::job_type q_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   dtaf_pkg::job_type entry;

   // build queue entry with the absolute sub-second value
   always_comb begin
      entry.secs = secs;
      entry.mag  = sub[dtaf_pkg::SUB_WIDTH-1] ? (~sub + 1'b1) : sub;
      entry.mode = mode;
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign job_valid  = (cnt_ff != 2'd0);
   assign pop        = job_valid && job_take;
   assign job        = q_ff[rd_ff];

   // advance pointers and fill count
   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // store request
   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= entry;
   end

endmodule

// File: sv/dtaf_convert.sv
// ----------------------------------------------------------------------------
// dtaf_convert: mixed-radix conversion
// Shifts seconds and fraction in two bits a cycle into digit registers.
// ----------------------------------------------------------------------------
module dtaf_convert (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_take,
   input  dtaf_pkg::job_type      job,
   output logic                   fld_valid,
   input  logic                   fld_take,
   output dtaf_pkg::fields_type   fld
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [4:0]                      step_ff, step_in;
   logic [dtaf_pkg::SECS_WIDTH-1:0] sreg_ff, sreg_in;
   logic [dtaf_pkg::SUB_WIDTH-1:0]  freg_ff, freg_in;
   dtaf_pkg::fields_type            acc_ff, acc_in;
   dtaf_pkg::fields_type            half;
   logic                            fen;

   assign job_take  = !busy_ff && !done_ff;
   assign fld_valid = done_ff;
   assign fld       = acc_ff;
   assign fen       = (step_ff < dtaf_pkg::FRAC_STEPS);

   // two doublings per cycle, most significant bits first
   always_comb begin
      half = dtaf_pkg::dbl_step(acc_ff, sreg_ff[dtaf_pkg::SECS_WIDTH-1],
                                freg_ff[dtaf_pkg::SUB_WIDTH-1], fen);
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      sreg_in = sreg_ff;
      freg_in = freg_ff;
      acc_in  = acc_ff;
      if (job_take && job_valid) begin
         busy_in = 1'b1;
         step_in = 5'd0;
         sreg_in = job.secs;
         freg_in = job.mag;
         acc_in  = '0;
         acc_in.mode = job.mode;
      end else if (busy_ff) begin
         acc_in = dtaf_pkg::dbl_step(half, sreg_ff[dtaf_pkg::SECS_WIDTH-2],
                                     freg_ff[dtaf_pkg::SUB_WIDTH-2], fen);
         sreg_in = {sreg_ff[dtaf_pkg::SECS_WIDTH-3:0], 2'b00};
         freg_in = {freg_ff[dtaf_pkg::SUB_WIDTH-3:0], 2'b00};
         step_in = step_ff + 5'd1;
         if (step_ff == dtaf_pkg::CONV_STEPS - 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (done_ff && fld_take) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      sreg_ff <= sreg_in;
      freg_ff <= freg_in;
      acc_ff  <= acc_in;
   end

endmodule

// File: sv/dtaf_emit.sv
// ----------------------------------------------------------------------------
// dtaf_emit: character sequencer
// Walks the formatted string to the output register, one char a cycle when free.
// ----------------------------------------------------------------------------
module dtaf_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fld_valid,
   output logic                 fld_take,
   input  dtaf_pkg::fields_type fld,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [5:0]           rsp_char,
   output logic                 rsp_last
);

   logic                 busy_ff, busy_in;
   logic [4:0]           idx_ff, idx_in;
   dtaf_pkg::fields_type cur_ff;
   logic                 vld_ff, vld_in;
   logic [5:0]           chr_ff, chr_in;
   logic                 lst_ff, lst_in;
   logic                 out_free;
   logic [4:0]           len;
   logic [5:0]           ch;

   assign fld_take   = !busy_ff;
   assign out_free   = !vld_ff || rsp_tready;
   assign rsp_tvalid = vld_ff;
   assign rsp_char   = chr_ff;
   assign rsp_last   = lst_ff;

   // string length for the held mode
   always_comb begin
      case (cur_ff.mode)
         dtaf_pkg::MODE_MICRO: len = dtaf_pkg::LEN_MICRO;
         dtaf_pkg::MODE_NANO:  len = dtaf_pkg::LEN_NANO;
         default:              len = dtaf_pkg::LEN_NONE;
      endcase
   end

   // select character at the current position
   always_comb begin
      ch = dtaf_pkg::CHAR_SPACE;
      case (idx_ff) inside
         [5'd0:5'd9]: ch = dtaf_pkg::CHAR_ZERO + 6'(cur_ff.days[4'(5'd9 - idx_ff)]);
         5'd10:       ch = dtaf_pkg::CHAR_SPACE;
         5'd11:       ch = dtaf_pkg::tens_char(6'(cur_ff.hours));
         5'd12:       ch = dtaf_pkg::units_char(6'(cur_ff.hours));
         5'd13:       ch = dtaf_pkg::CHAR_COLON;
         5'd14:       ch = dtaf_pkg::tens_char(cur_ff.mins);
         5'd15:       ch = dtaf_pkg::units_char(cur_ff.mins);
         5'd16:       ch = dtaf_pkg::CHAR_COLON;
         5'd17:       ch = dtaf_pkg::tens_char(cur_ff.secs);
         5'd18:       ch = dtaf_pkg::units_char(cur_ff.secs);
         5'd19:       ch = dtaf_pkg::CHAR_DOT;
         default: begin
            if (cur_ff.mode == dtaf_pkg::MODE_NANO)
               ch = dtaf_pkg::CHAR_ZERO + 6'(cur_ff.frac[4'(5'd28 - idx_ff)]);
            else
               ch = dtaf_pkg::CHAR_ZERO + 6'(cur_ff.frac[4'(5'd25 - idx_ff)]);
         end
      endcase
   end

   // advance position and fill output register
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      vld_in  = vld_ff;
      chr_in  = chr_ff;
      lst_in  = lst_ff;
      if (out_free) begin
         vld_in = busy_ff;
         if (busy_ff) begin
            chr_in = ch;
            lst_in = (idx_ff == len - 5'd1);
            idx_in = idx_ff + 5'd1;
            if (idx_ff == len - 5'd1) busy_in = 1'b0;
         end
      end
      if (fld_take && fld_valid) begin
         busy_in = 1'b1;
         idx_in  = 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      chr_ff <= chr_in;
      lst_ff <= lst_in;
      if (fld_take && fld_valid) cur_ff <= fld;
   end

endmodule

// File: dv/tb_duration_to_ascii_formatter_unit.sv
// ----------------------------------------------------------------------------
// tb_duration_to_ascii_formatter_unit: self-checking bench of the formatter
// Sends durations under each fraction mode, predicts the text of each request
// and compares every streamed character and its last flag in order.
// ----------------------------------------------------------------------------
module tb_duration_to_ascii_formatter_unit;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 80;
   localparam int HOLD_CYCLES    = 300;

   typedef struct packed {
      logic [5:0] ch;
      logic       last;
   } char_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   logic [1:0]  mode_shadow;
   char_type    text_queue[$];
   int          error_count;
   int          idle_cycles;
   bit          hold_req;
   bit          timed_out;

   duration_to_ascii_formatter_unit dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   // append decimal digits of a value, most significant first
   task automatic push_digits(input logic [63:0] value, input int ndigits);
      logic [63:0] div;
      char_type    c;
      div = 64'd1;
      for (int i = 1; i < ndigits; i++) div = div * 64'd10;
      for (int i = 0; i < ndigits; i++) begin
         c.ch   = dtaf_pkg::CHAR_ZERO + 6'((value / div) % 64'd10);
         c.last = 1'b0;
         text_queue.push_back(c);
         div = div / 64'd10;
      end
   endtask

   task automatic push_char(input logic [5:0] ch);
      char_type c;
      c.ch   = ch;
      c.last = 1'b0;
      text_queue.push_back(c);
   endtask

   // predict the formatted text of one request
   task automatic predict_text(input logic [49:0] secs, input logic [31:0] sub);
      logic [63:0] s64;
      logic [63:0] rem;
      logic [31:0] mag;
      char_type    c;
      s64 = 64'(secs);
      mag = sub[31] ? (32'd0 - sub) : sub;
      rem = s64 % 64'd86400;
      push_digits((s64 / 64'd86400) % 64'd10000000000, 10);
      push_char(dtaf_pkg::CHAR_SPACE);
      push_digits(rem / 64'd3600, 2);
      push_char(dtaf_pkg::CHAR_COLON);
      push_digits((rem % 64'd3600) / 64'd60, 2);
      push_char(dtaf_pkg::CHAR_COLON);
      push_digits(rem % 64'd60, 2);
      if (mode_shadow == dtaf_pkg::MODE_MICRO) begin
         push_char(dtaf_pkg::CHAR_DOT);
         push_digits(64'(mag % 32'd1000000), 6);
      end else if (mode_shadow == dtaf_pkg::MODE_NANO) begin
         push_char(dtaf_pkg::CHAR_DOT);
         push_digits(64'(mag % 32'd1000000000), 9);
      end
      c = text_queue.pop_back();
      c.last = 1'b1;
      text_queue.push_back(c);
   endtask

   // offer one request after a random gap, hold until accepted
   task automatic send_request(input logic [49:0] secs, input logic [31:0] sub);
      int gap;
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, sub, secs};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_text(secs, sub);
   endtask

   // drop the request line after the last request of a sequence
   task automatic stop_requests();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (text_queue.size() != 0 && !timed_out) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [1:0] mode);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we    <= 1'b0;
      mode_shadow = mode;
   endtask

   function automatic logic [49:0] rand_secs();
      logic [49:0] v;
      v = 50'({$urandom, $urandom});
      case ($urandom_range(0, 3))
         0: v = v % 50'd864000000000000;
         1: v = v % 50'd86400;
         2: v = v % 50'd863999999999999 + 50'd1;
         default: ;
      endcase
      return v;
   endfunction

   // extremes of the fields, day boundaries, most negative sub-second
   task automatic test_directed();
      send_request(50'd0, 32'd0);
      send_request(50'd863999999999999, 32'h7fffffff);
      send_request(50'd86399, 32'h80000000);
      send_request(50'd86400, 32'hffffffff);
      send_request(50'd3599, 32'd999999);
      send_request(50'd3600, 32'd1000000);
      send_request(50'd59, -32'sd999999999);
      send_request(50'd60, 32'd1000000000);
      send_request({50{1'b1}}, 32'h80000001);
      send_request(50'h2aaaaaaaaaaaa, 32'h55555555);
      send_request(50'h1555555555555, 32'haaaaaaaa);
      send_request(50'd864000000000000, 32'd123456789);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) send_request(rand_secs(), $urandom);
   endtask

   // receiver holds off long enough that the block backs up its input
   task automatic test_backpressure();
      wait_idle();
      hold_req = 1'b1;
      test_random(8);
      stop_requests();
   endtask

   task automatic run_mode_phase(input logic [1:0] mode, input int count);
      write_mode(mode);
      test_directed();
      test_random(count);
      stop_requests();
   endtask

   // receiver side: random stalls, long hold on request, compare in order
   initial begin
      char_type exp;
      int       wait_left;
      int       hold_left;
      wait_left = 0;
      hold_left = 0;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (text_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected character %02h", rsp_tdata));
            end else begin
               exp = text_queue.pop_front();
               if (rsp_tdata != {2'b00, exp.ch})
                  report_mismatch($sformatf("character %02h, expected %02h",
                                            rsp_tdata, exp.ch));
               if (rsp_tlast != exp.last)
                  report_mismatch($sformatf("last flag %0b, expected %0b",
                                            rsp_tlast, exp.last));
            end
            wait_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
         end
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no accepted transfer
   initial begin
      idle_cycles = 0;
      timed_out   = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else if (text_queue.size() != 0 || req_tvalid) idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      error_count = 0;
      hold_req    = 1'b0;
      mode_shadow = dtaf_pkg::MODE_NONE;
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_wdata  <= dtaf_pkg::MODE_NONE;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      stop_requests();
      run_mode_phase(dtaf_pkg::MODE_MICRO, 80);
      run_mode_phase(dtaf_pkg::MODE_NANO, 80);
      test_backpressure();
      run_mode_phase(dtaf_pkg::MODE_SPARE, 50);
      run_mode_phase(dtaf_pkg::MODE_NONE, 60);
      run_mode_phase(dtaf_pkg::MODE_NANO, 40);
      wait_idle();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
